FILE: hw/rtl/tps_pkg.sv
`default_nettype none
package tps_pkg;

  typedef enum logic [2:0] {
    ACT_TICK    = 3'd0,
    ACT_NOTIFY  = 3'd1,
    ACT_MUSIC   = 3'd2,
    ACT_EFFECTS = 3'd3,
    ACT_SILENCE = 3'd4
  } act_t;

  localparam logic [1:0] VOICE_BASS = 2'd0;
  localparam logic [1:0] VOICE_LEAD = 2'd1;
  localparam logic [1:0] VOICE_PERC = 2'd2;
  localparam logic [1:0] VOICE_FX   = 2'd3;

  localparam logic [11:0] FREQ_KICK     = 12'd82;
  localparam logic [11:0] FREQ_HAT      = 12'd2489;
  localparam logic [11:0] FREQ_TAIL_HI  = 12'd1319;
  localparam logic [11:0] FREQ_TAIL_LO  = 12'd784;
  localparam logic [11:0] FREQ_FX_HI    = 12'd880;
  localparam logic [11:0] FREQ_FX_LO    = 12'd523;

  localparam logic [7:0] DUR_BASS = 8'd220;
  localparam logic [7:0] DUR_LEAD = 8'd90;
  localparam logic [7:0] DUR_KICK = 8'd45;
  localparam logic [7:0] DUR_HAT  = 8'd12;
  localparam logic [7:0] DUR_TAIL = 8'd65;
  localparam logic [7:0] DUR_FX   = 8'd45;

  localparam int QDEPTH = 2;

  typedef struct packed {
    act_t        act;
    logic [31:0] now_ms;
    logic        enable;
    logic        name_resolved;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  voice;
    logic        is_stop;
    logic [11:0] freq_hz;
    logic [7:0]  duration_ms;
  } note_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic note_t mk_note(input logic [1:0] v, input logic s,
                                    input logic [11:0] f, input logic [7:0] d);
    note_t n;
    n.voice       = v;
    n.is_stop     = s;
    n.freq_hz     = f;
    n.duration_ms = d;
    return n;
  endfunction

  function automatic logic [11:0] bass_freq(input logic [1:0] chord);
    logic [11:0] f;
    case (chord)
      2'd0: f = 12'd147;
      2'd1: f = 12'd131;
      2'd2: f = 12'd117;
      2'd3: f = 12'd110;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

  function automatic logic [1:0] arp_idx(input logic [2:0] pos);
    logic [1:0] i;
    case (pos)
      3'd0: i = 2'd0;
      3'd1: i = 2'd2;
      3'd2: i = 2'd1;
      3'd3: i = 2'd3;
      3'd4: i = 2'd2;
      3'd5: i = 2'd1;
      3'd6: i = 2'd0;
      3'd7: i = 2'd2;
      default: i = 2'd0;
    endcase
    return i;
  endfunction

  function automatic logic [11:0] lead_freq(input logic [1:0] chord,
                                            input logic [2:0] pos);
    logic [11:0] f;
    case ({chord, arp_idx(pos)})
      4'd0:  f = 12'd294;
      4'd1:  f = 12'd349;
      4'd2:  f = 12'd440;
      4'd3:  f = 12'd587;
      4'd4:  f = 12'd262;
      4'd5:  f = 12'd330;
      4'd6:  f = 12'd392;
      4'd7:  f = 12'd524;
      4'd8:  f = 12'd233;
      4'd9:  f = 12'd294;
      4'd10: f = 12'd349;
      4'd11: f = 12'd466;
      4'd12: f = 12'd220;
      4'd13: f = 12'd262;
      4'd14: f = 12'd330;
      4'd15: f = 12'd440;
      default: f = 12'd0;
    endcase
    return f;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/tps_front.sv
`default_nettype none
module tps_front (
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [2:0]     in_action,
  input  wire logic [31:0]    in_now_ms,
  input  wire logic           in_enable,
  input  wire logic           in_name_resolved,
  input  wire tps_pkg::qstat_t q_stat,
  output logic                q_push,
  output tps_pkg::cmd_t       q_cmd
);

  logic known;

  always_comb begin
    case (in_action)
      tps_pkg::ACT_TICK,
      tps_pkg::ACT_NOTIFY,
      tps_pkg::ACT_MUSIC,
      tps_pkg::ACT_EFFECTS,
      tps_pkg::ACT_SILENCE: known = 1'b1;
      default:              known = 1'b0;
    endcase
  end

  // Items with an unknown action are taken and dropped here.
  assign in_stall            = q_stat.full;
  assign q_push              = in_valid && !q_stat.full && known;
  assign q_cmd.act           = tps_pkg::act_t'(in_action);
  assign q_cmd.now_ms        = in_now_ms;
  assign q_cmd.enable        = in_enable;
  assign q_cmd.name_resolved = in_name_resolved;

endmodule
`default_nettype wire

FILE: hw/rtl/tps_queue.sv
`default_nettype none
module tps_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tps_pkg::cmd_t  push_cmd,
  input  wire logic           pop,
  output tps_pkg::cmd_t       head,
  output tps_pkg::qstat_t     stat
);

  localparam int PW = $clog2(tps_pkg::QDEPTH);
  localparam int CW = $clog2(tps_pkg::QDEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(tps_pkg::QDEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(tps_pkg::QDEPTH);

  tps_pkg::cmd_t   slot_r [tps_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);

endmodule
`default_nettype wire

FILE: hw/rtl/tps_back.sv
`default_nettype none
module tps_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [15:0]     beat_period_ms,
  input  wire logic [15:0]     tail_delay_ms,
  input  wire logic [15:0]     effect_window_ms,
  input  wire tps_pkg::qstat_t q_stat,
  input  wire tps_pkg::cmd_t   q_head,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output tps_pkg::note_t       out_note,
  output logic                 out_last
);

  localparam int NSLOTS    = 5;
  localparam int SW        = $clog2(NSLOTS);
  localparam int SLOT_BASS = 0;
  localparam int SLOT_LEAD = 1;
  localparam int SLOT_PERC = 2;
  localparam int SLOT_FXA  = 3;
  localparam int SLOT_FXB  = 4;
  localparam int DIV_STEPS = 32;
  localparam int CNTW      = $clog2(DIV_STEPS);
  localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DIV_STEPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_NOTES,
    ST_FX,
    ST_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic            music_on_r, music_on_nxt;
  logic            effects_on_r, effects_on_nxt;
  logic [6:0]      step_r, step_nxt;
  logic [31:0]     last_beat_r, last_beat_nxt;
  logic [31:0]     last_fx_r, last_fx_nxt;
  logic            fx_pend_r, fx_pend_nxt;
  logic            pend_named_r, pend_named_nxt;
  logic            play_named_r, play_named_nxt;
  logic            tail_due_r, tail_due_nxt;
  logic            fx_tvalid_r, fx_tvalid_nxt;
  logic [31:0]     now_r, now_nxt;
  logic [31:0]     dvd_r, dvd_nxt;
  logic [15:0]     rem_r, rem_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic [NSLOTS-1:0] mask_r, mask_nxt;
  tps_pkg::note_t  slot_r [NSLOTS];
  tps_pkg::note_t  slot_nxt [NSLOTS];
  logic            out_valid_r, out_valid_nxt;
  tps_pkg::note_t  out_note_r, out_note_nxt;
  logic            out_last_r, out_last_nxt;

  logic [15:0]       period_w;
  logic [31:0]       head_el;
  logic [16:0]       rem_sh, rem_sub;
  logic              div_ge;
  logic [6:0]        step_s;
  logic [1:0]        chord;
  logic [31:0]       fx_el;
  logic              tail_go, fx_go;
  logic [SW-1:0]     pick;
  logic [NSLOTS-1:0] mask_rest;
  logic              out_free;

  assign period_w  = (beat_period_ms == 16'd0) ? 16'd1 : beat_period_ms;
  assign head_el   = q_head.now_ms - last_beat_r;
  assign rem_sh    = {rem_r, dvd_r[31]};
  assign div_ge    = rem_sh >= {1'b0, period_w};
  assign rem_sub   = rem_sh - {1'b0, period_w};
  assign step_s    = step_r + dvd_r[6:0] - 7'd1;
  assign chord     = step_s[6:5];
  assign fx_el     = now_r - last_fx_r;
  assign tail_go   = tail_due_r && (fx_el >= {16'd0, tail_delay_ms});
  assign fx_go     = effects_on_r && fx_pend_r &&
                     (!fx_tvalid_r || (fx_el >= {16'd0, effect_window_ms}));
  assign out_free  = !out_valid_r || !out_stall;
  assign q_pop     = (state_r == ST_IDLE) && !q_stat.empty;
  assign mask_rest = mask_r & ~(NSLOTS'(1) << pick);

  always_comb begin
    pick = '0;
    for (int i = NSLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        pick = SW'(i);
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    music_on_nxt   = music_on_r;
    effects_on_nxt = effects_on_r;
    step_nxt       = step_r;
    last_beat_nxt  = last_beat_r;
    last_fx_nxt    = last_fx_r;
    fx_pend_nxt    = fx_pend_r;
    pend_named_nxt = pend_named_r;
    play_named_nxt = play_named_r;
    tail_due_nxt   = tail_due_r;
    fx_tvalid_nxt  = fx_tvalid_r;
    now_nxt        = now_r;
    dvd_nxt        = dvd_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    mask_nxt       = mask_r;
    slot_nxt       = slot_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_note_nxt   = out_note_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          slot_nxt[SLOT_BASS] = tps_pkg::mk_note(tps_pkg::VOICE_BASS, 1'b1, '0, '0);
          slot_nxt[SLOT_LEAD] = tps_pkg::mk_note(tps_pkg::VOICE_LEAD, 1'b1, '0, '0);
          slot_nxt[SLOT_PERC] = tps_pkg::mk_note(tps_pkg::VOICE_PERC, 1'b1, '0, '0);
          slot_nxt[SLOT_FXA]  = tps_pkg::mk_note(tps_pkg::VOICE_FX, 1'b1, '0, '0);
          case (q_head.act)
            tps_pkg::ACT_TICK: begin
              now_nxt = q_head.now_ms;
              if (music_on_r && (head_el >= {16'd0, period_w})) begin
                dvd_nxt   = head_el;
                rem_nxt   = '0;
                cnt_nxt   = '0;
                state_nxt = ST_DIV;
              end else begin
                state_nxt = ST_FX;
              end
            end
            tps_pkg::ACT_NOTIFY: begin
              if (effects_on_r) begin
                fx_pend_nxt    = 1'b1;
                pend_named_nxt = pend_named_r || q_head.name_resolved;
              end
            end
            tps_pkg::ACT_MUSIC: begin
              music_on_nxt  = q_head.enable;
              step_nxt      = '0;
              last_beat_nxt = q_head.now_ms - {16'd0, beat_period_ms};
              if (!q_head.enable) begin
                mask_nxt[SLOT_BASS] = 1'b1;
                mask_nxt[SLOT_LEAD] = 1'b1;
                mask_nxt[SLOT_PERC] = 1'b1;
                state_nxt           = ST_EMIT;
              end
            end
            tps_pkg::ACT_EFFECTS: begin
              effects_on_nxt = q_head.enable;
              fx_pend_nxt    = 1'b0;
              pend_named_nxt = 1'b0;
              tail_due_nxt   = 1'b0;
              fx_tvalid_nxt  = 1'b0;
              if (!q_head.enable) begin
                mask_nxt[SLOT_FXA] = 1'b1;
                state_nxt          = ST_EMIT;
              end
            end
            tps_pkg::ACT_SILENCE: begin
              music_on_nxt        = 1'b0;
              step_nxt            = '0;
              last_beat_nxt       = 32'd0 - {16'd0, beat_period_ms};
              effects_on_nxt      = 1'b0;
              fx_pend_nxt         = 1'b0;
              pend_named_nxt      = 1'b0;
              tail_due_nxt        = 1'b0;
              fx_tvalid_nxt       = 1'b0;
              mask_nxt[SLOT_BASS] = 1'b1;
              mask_nxt[SLOT_LEAD] = 1'b1;
              mask_nxt[SLOT_PERC] = 1'b1;
              mask_nxt[SLOT_FXA]  = 1'b1;
              state_nxt           = ST_EMIT;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        rem_nxt = div_ge ? rem_sub[15:0] : rem_sh[15:0];
        dvd_nxt = {dvd_r[30:0], div_ge};
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNT_LAST) begin
          state_nxt = ST_NOTES;
        end
      end
      ST_NOTES: begin
        slot_nxt[SLOT_BASS] = tps_pkg::mk_note(tps_pkg::VOICE_BASS, 1'b0,
                                               tps_pkg::bass_freq(chord), tps_pkg::DUR_BASS);
        slot_nxt[SLOT_LEAD] = tps_pkg::mk_note(tps_pkg::VOICE_LEAD, 1'b0,
                                               tps_pkg::lead_freq(chord, step_s[2:0]),
                                               tps_pkg::DUR_LEAD);
        if (step_s[1:0] == 2'd0) begin
          slot_nxt[SLOT_PERC] = tps_pkg::mk_note(tps_pkg::VOICE_PERC, 1'b0,
                                                 tps_pkg::FREQ_KICK, tps_pkg::DUR_KICK);
        end else begin
          slot_nxt[SLOT_PERC] = tps_pkg::mk_note(tps_pkg::VOICE_PERC, 1'b0,
                                                 tps_pkg::FREQ_HAT, tps_pkg::DUR_HAT);
        end
        mask_nxt[SLOT_BASS] = !step_s[0];
        mask_nxt[SLOT_LEAD] = 1'b1;
        mask_nxt[SLOT_PERC] = (step_s[1:0] == 2'd0) || step_s[0];
        step_nxt            = step_s + 7'd1;
        last_beat_nxt       = now_r;
        state_nxt           = ST_FX;
      end
      ST_FX: begin
        if (tail_go) begin
          slot_nxt[SLOT_FXA] = tps_pkg::mk_note(tps_pkg::VOICE_FX, 1'b0,
              play_named_r ? tps_pkg::FREQ_TAIL_HI : tps_pkg::FREQ_TAIL_LO,
              tps_pkg::DUR_TAIL);
          mask_nxt[SLOT_FXA] = 1'b1;
          tail_due_nxt       = 1'b0;
        end
        if (fx_go) begin
          slot_nxt[SLOT_FXB] = tps_pkg::mk_note(tps_pkg::VOICE_FX, 1'b0,
              pend_named_r ? tps_pkg::FREQ_FX_HI : tps_pkg::FREQ_FX_LO,
              tps_pkg::DUR_FX);
          mask_nxt[SLOT_FXB] = 1'b1;
          play_named_nxt     = pend_named_r;
          fx_pend_nxt        = 1'b0;
          pend_named_nxt     = 1'b0;
          last_fx_nxt        = now_r;
          fx_tvalid_nxt      = 1'b1;
          tail_due_nxt       = 1'b1;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (mask_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_note_nxt  = slot_r[pick];
          out_last_nxt  = (mask_rest == '0);
          mask_nxt      = mask_rest;
          if (mask_rest == '0) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      music_on_r   <= 1'b0;
      effects_on_r <= 1'b0;
      step_r       <= '0;
      last_beat_r  <= '0;
      last_fx_r    <= '0;
      fx_pend_r    <= 1'b0;
      pend_named_r <= 1'b0;
      play_named_r <= 1'b0;
      tail_due_r   <= 1'b0;
      fx_tvalid_r  <= 1'b0;
      cnt_r        <= '0;
      mask_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      music_on_r   <= music_on_nxt;
      effects_on_r <= effects_on_nxt;
      step_r       <= step_nxt;
      last_beat_r  <= last_beat_nxt;
      last_fx_r    <= last_fx_nxt;
      fx_pend_r    <= fx_pend_nxt;
      pend_named_r <= pend_named_nxt;
      play_named_r <= play_named_nxt;
      tail_due_r   <= tail_due_nxt;
      fx_tvalid_r  <= fx_tvalid_nxt;
      cnt_r        <= cnt_nxt;
      mask_r       <= mask_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    now_r      <= now_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    slot_r     <= slot_nxt;
    out_note_r <= out_note_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_note  = out_note_r;
  assign out_last  = out_last_r;

endmodule
`default_nettype wire

FILE: hw/rtl/tone_pattern_sequencer_core.sv
// A tick that plays a step holds the command engine through the 32-step serial divider,
// which works out how many beats have passed, then through note building, effects and
// emitting its commands; other ticks skip the divider and note building. Notify is
// handled on the pop alone; set music, set effects and silence emit any stops after it.
// Synchronous active-low reset clears the control state and restores register defaults;
// data registers such as the queue slots and the output note are not reset.
`default_nettype none
module tone_pattern_sequencer_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_action,
  input  wire logic [31:0] in_now_ms,
  input  wire logic        in_enable,
  input  wire logic        in_name_resolved,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_voice,
  output logic             out_is_stop,
  output logic [11:0]      out_freq_hz,
  output logic [7:0]       out_duration_ms,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] REG_BEAT   = 2'd0;
  localparam logic [1:0] REG_TAIL   = 2'd1;
  localparam logic [1:0] REG_WINDOW = 2'd2;

  logic [15:0] beat_r, tail_r, window_r;
  logic        cfg_wr;

  tps_pkg::qstat_t q_stat;
  tps_pkg::cmd_t   q_cmd, q_head;
  logic            q_push, q_pop;
  tps_pkg::note_t  out_note;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r   <= 16'd134;
      tail_r   <= 16'd65;
      window_r <= 16'd750;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_BEAT:   beat_r   <= pwdata[15:0];
        REG_TAIL:   tail_r   <= pwdata[15:0];
        REG_WINDOW: window_r <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_BEAT:   prdata = {16'd0, beat_r};
      REG_TAIL:   prdata = {16'd0, tail_r};
      REG_WINDOW: prdata = {16'd0, window_r};
      default:    prdata = '0;
    endcase
  end

  tps_front u_front (
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_now_ms        (in_now_ms),
    .in_enable        (in_enable),
    .in_name_resolved (in_name_resolved),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_cmd            (q_cmd)
  );

  tps_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  tps_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .beat_period_ms   (beat_r),
    .tail_delay_ms    (tail_r),
    .effect_window_ms (window_r),
    .q_stat           (q_stat),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_note         (out_note),
    .out_last         (out_last)
  );

  assign out_voice       = out_note.voice;
  assign out_is_stop     = out_note.is_stop;
  assign out_freq_hz     = out_note.freq_hz;
  assign out_duration_ms = out_note.duration_ms;

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("item pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("item popped from an empty queue");

  a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

endmodule
`default_nettype wire
